>>> src/sfd_pkg.sv
// Shared types, defaults and command decoding for the serial frame deframer.
`default_nettype none
package sfd_pkg;

    typedef logic [7:0] t_byte;

    localparam int    MAX_BODY_DEF   = 16;
    localparam t_byte START_BYTE_RST = 8'h01;
    localparam t_byte END_BYTE_RST   = 8'h FE;

    // Configuration register indexes
    localparam t_byte CFG_START_BYTE = 8'd0;
    localparam t_byte CFG_END_BYTE   = 8'd1;

    localparam t_byte CMD_20 = 8'h20;
    localparam t_byte CMD_25 = 8'h25;
    localparam t_byte CMD_26 = 8'h26;
    localparam t_byte CMD_27 = 8'h27;
    localparam t_byte CMD_55 = 8'h55;
    localparam t_byte CMD_60 = 8'h60;

    function automatic logic cmd_ok(input t_byte c);
        return (c == CMD_20) || (c == CMD_25) || (c == CMD_26) ||
               (c == CMD_27) || (c == CMD_55) || (c == CMD_60);
    endfunction

endpackage
`default_nettype wire

>>> src/sfd_cell.sv
// One byte cell of the body shift chain.
`default_nettype none
module sfd_cell (
    input  wire logic          i_clk,
    input  wire logic          i_shift,
    input  wire sfd_pkg::t_byte i_data,
    output sfd_pkg::t_byte     o_data
);
    import sfd_pkg::*;

    t_byte r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

>>> src/sfd_chain.sv
// Row of byte cells: bytes enter at cell 0 and move up one cell per shift.
`default_nettype none
module sfd_chain #(
    parameter int MAX_BODY = sfd_pkg::MAX_BODY_DEF,
    parameter int IDX_W    = $clog2(MAX_BODY)
) (
    input  wire logic             i_clk,
    input  wire logic             i_shift,
    input  wire sfd_pkg::t_byte   i_data,
    input  wire logic [IDX_W-1:0] i_tap_idx,
    output sfd_pkg::t_byte        o_tap
);
    import sfd_pkg::*;

    t_byte w_cell [MAX_BODY];

    for (genvar k = 0; k < MAX_BODY; k++) begin : g_cell
        if (k == 0) begin : g_head
            sfd_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(i_shift),
                .i_data (i_data),
                .o_data (w_cell[k])
            );
        end else begin : g_link
            sfd_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(i_shift),
                .i_data (w_cell[k-1]),
                .o_data (w_cell[k])
            );
        end
    end

    // During replay the next payload byte always sits at the tap while the chain shifts
    assign o_tap = w_cell[i_tap_idx];

endmodule
`default_nettype wire

>>> src/serial_frame_deframer.sv
// Serial frame deframer: frame control, checks and result output register.
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_rx_byte): one received byte
//   per item. Outside a frame only the start byte matters; inside a frame
//   bytes are stored in a chain of byte cells until the end byte.
//   Output channel (o_out_valid / i_out_stall): one item per payload byte
//   of an accepted frame, or one item with payload_valid low for an empty
//   payload; last marks the final item of the frame.
//   Config channel (i_cfg_valid / o_cfg_ready): index 0 start byte, index 1
//   end byte; other indexes are ignored. Always ready.
// Timing:
//   The input is stalled only after the end byte of an accepted frame,
//   while the payload is replayed out of the cell chain, one result per
//   cycle while the output is not stalled: one result per payload byte
//   (at most MAX_BODY-2), one for an empty payload. The end byte moves
//   the control to the replay state, which loads the output register.
//   A stall on the output holds the result register and the replay; the
//   input is taken again once the final result is loaded.
// Reset: synchronous, active low; the block is idle outside any frame and
// the registers return to start 0x01 and end 0xFE.
`default_nettype none
module serial_frame_deframer #(
    parameter int MAX_BODY = sfd_pkg::MAX_BODY_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire sfd_pkg::t_byte i_rx_byte,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output sfd_pkg::t_byte      o_command,
    output sfd_pkg::t_byte      o_frame_length,
    output sfd_pkg::t_byte      o_payload_byte,
    output logic                o_payload_valid,
    output logic                o_last,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire sfd_pkg::t_byte i_cfg_index,
    input  wire sfd_pkg::t_byte i_cfg_data
);
    import sfd_pkg::*;

    localparam int CNT_W = $clog2(MAX_BODY + 1);
    localparam int IDX_W = $clog2(MAX_BODY);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FRAME = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_left, n_left;
    logic [IDX_W-1:0] r_tap, n_tap;
    logic             r_empty, n_empty;
    t_byte            r_cmd, n_cmd;
    t_byte            r_len, n_len;
    t_byte            r_start, r_end;

    logic  r_out_valid, n_out_valid;
    t_byte r_out_cmd, n_out_cmd;
    t_byte r_out_len, n_out_len;
    t_byte r_out_data, n_out_data;
    logic  r_out_pv, n_out_pv;
    logic  r_out_last, n_out_last;

    logic  w_in_acc;
    logic  w_out_free;
    logic  w_shift;
    t_byte w_tap;
    logic  w_frame_ok;

    assign o_in_stall = (r_state == ST_EMIT);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign w_frame_ok = (r_count >= CNT_W'(2)) && cmd_ok(r_cmd) &&
                        (r_len == (8'(r_count) + 8'd2));

    sfd_chain #(
        .MAX_BODY(MAX_BODY),
        .IDX_W   (IDX_W)
    ) u_chain (
        .i_clk    (i_clk),
        .i_shift  (w_shift),
        .i_data   (i_rx_byte),
        .i_tap_idx(r_tap),
        .o_tap    (w_tap)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_tap       = r_tap;
        n_empty     = r_empty;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_cmd   = r_out_cmd;
        n_out_len   = r_out_len;
        n_out_data  = r_out_data;
        n_out_pv    = r_out_pv;
        n_out_last  = r_out_last;
        w_shift     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_rx_byte == r_start)) begin
                    n_state = ST_FRAME;
                    n_count = '0;
                end
            end
            ST_FRAME: begin
                if (w_in_acc) begin
                    if (i_rx_byte == r_end) begin
                        n_state = w_frame_ok ? ST_EMIT : ST_IDLE;
                        n_left  = r_count - CNT_W'(2);
                        n_empty = (r_count == CNT_W'(2));
                        // first payload byte sits at cell count-3
                        n_tap   = IDX_W'(r_count - CNT_W'(3));
                    end else if (r_count >= CNT_W'(MAX_BODY)) begin
                        n_state = ST_IDLE;
                        n_count = '0;
                    end else begin
                        w_shift = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        if (r_count == CNT_W'(0)) begin
                            n_cmd = i_rx_byte;
                        end
                        if (r_count == CNT_W'(1)) begin
                            n_len = i_rx_byte;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cmd   = r_cmd;
                    n_out_len   = r_len;
                    n_out_data  = r_empty ? 8'd0 : w_tap;
                    n_out_pv    = !r_empty;
                    n_out_last  = r_empty || (r_left == CNT_W'(1));
                    w_shift     = !r_empty;
                    n_left      = r_left - CNT_W'(1);
                    if (r_empty || (r_left == CNT_W'(1))) begin
                        n_state = ST_IDLE;
                        n_count = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_start     <= START_BYTE_RST;
            r_end       <= END_BYTE_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_START_BYTE) begin
                    r_start <= i_cfg_data;
                end else if (i_cfg_index == CFG_END_BYTE) begin
                    r_end <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_tap      <= n_tap;
        r_empty    <= n_empty;
        r_cmd      <= n_cmd;
        r_len      <= n_len;
        r_out_cmd  <= n_out_cmd;
        r_out_len  <= n_out_len;
        r_out_data <= n_out_data;
        r_out_pv   <= n_out_pv;
        r_out_last <= n_out_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_command       = r_out_cmd;
    assign o_frame_length  = r_out_len;
    assign o_payload_byte  = r_out_data;
    assign o_payload_valid = r_out_pv;
    assign o_last          = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BODY))
        else $error("body count beyond store depth");

    a_emit_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_empty || (r_left != '0)))
        else $error("replay state with nothing left to send");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_payload_valid) |-> o_last)
        else $error("empty payload item not marked last");

    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && $past(r_state == ST_EMIT) && w_out_free) |=>
        (o_out_valid && ((r_state == ST_EMIT) != o_last)))
        else $error("replay end and last flag disagree");

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for serial_frame_deframer: directed table, random frames, config phases.
`timescale 1ns / 1ps

module tb_top;
    import sfd_pkg::*;

    localparam int BODY_DEPTH     = MAX_BODY_DEF;
    localparam int ITEMS_PER_PASS = 40;
    localparam int NUM_PASSES     = 5;
    localparam int SETTLE_CYCLES  = 20;
    localparam int QUIET_LIMIT    = 2000;
    // not mapped to any register, must be ignored
    localparam t_byte REG_UNMAPPED = 8'd2;

    typedef struct packed {
        t_byte command;
        t_byte frame_length;
        t_byte payload_byte;
        logic  payload_valid;
        logic  is_last;
    } t_frame_result;

    typedef enum logic [1:0] {ROW_MODEL, ROW_QUIET, ROW_ONE} t_row_check;

    typedef enum logic [2:0] {
        FR_GOOD, FR_MAX, FR_BADLEN, FR_BADCMD, FR_SHORT, FR_OVERFLOW, FR_NOISE
    } t_frame_kind;

    typedef struct packed {
        t_byte         rx;
        t_row_check    chk;
        t_frame_result res;
    } t_dir_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    t_byte         i_rx_byte = '0;
    logic          i_out_stall = 1'b0;
    logic          i_cfg_valid = 1'b0;
    t_byte         i_cfg_index = '0;
    t_byte         i_cfg_data = '0;
    logic          o_in_stall;
    logic          o_out_valid;
    t_byte         o_command;
    t_byte         o_frame_length;
    t_byte         o_payload_byte;
    logic          o_payload_valid;
    logic          o_last;
    logic          o_cfg_ready;

    // how the item on the input port is checked, moves with the item
    t_row_check    row_chk = ROW_MODEL;
    t_frame_result row_res = '0;

    // deframer model state
    t_byte         cfg_start = START_BYTE_RST;
    t_byte         cfg_end = END_BYTE_RST;
    logic          fr_open = 1'b0;
    int            body_len = 0;
    t_byte         body_buf [BODY_DEPTH];
    t_frame_result frame_replay [$];
    t_frame_result due_results [$];

    int            mismatches = 0;
    int            results_seen = 0;
    int            frame_items = 0;
    int            reg_writes = 0;
    int            quiet_cycles = 0;
    int            frame_no = 0;
    int            stall_left = 0;
    logic          send_calm = 1'b0;
    logic          out_calm = 1'b0;

    t_byte good_cmds [6] = '{CMD_20, CMD_25, CMD_26, CMD_27, CMD_55, CMD_60};

    // default register values throughout
    t_dir_row dir_rows [35] = '{
        '{8'h33,          ROW_QUIET, '0},   // ignored outside a frame
        '{END_BYTE_RST,   ROW_QUIET, '0},
        '{START_BYTE_RST, ROW_QUIET, '0},   // empty payload
        '{CMD_20,         ROW_QUIET, '0},
        '{8'h04,          ROW_QUIET, '0},
        '{END_BYTE_RST,   ROW_ONE,   '{CMD_20, 8'h04, 8'h00, 1'b0, 1'b1}},
        '{START_BYTE_RST, ROW_QUIET, '0},   // no body at all
        '{END_BYTE_RST,   ROW_QUIET, '0},
        '{START_BYTE_RST, ROW_QUIET, '0},   // command only
        '{CMD_25,         ROW_QUIET, '0},
        '{END_BYTE_RST,   ROW_QUIET, '0},
        '{START_BYTE_RST, ROW_QUIET, '0},   // unknown command
        '{8'h21,          ROW_QUIET, '0},
        '{8'h04,          ROW_QUIET, '0},
        '{END_BYTE_RST,   ROW_QUIET, '0},
        '{START_BYTE_RST, ROW_QUIET, '0},   // length off by one
        '{CMD_27,         ROW_QUIET, '0},
        '{8'h05,          ROW_QUIET, '0},
        '{END_BYTE_RST,   ROW_QUIET, '0},
        '{START_BYTE_RST, ROW_QUIET, '0},   // start byte kept as payload
        '{CMD_26,         ROW_QUIET, '0},
        '{8'h07,          ROW_QUIET, '0},
        '{8'h00,          ROW_QUIET, '0},
        '{START_BYTE_RST, ROW_QUIET, '0},
        '{8'hFF,          ROW_QUIET, '0},
        '{END_BYTE_RST,   ROW_MODEL, '0},
        '{START_BYTE_RST, ROW_QUIET, '0},
        '{CMD_55,         ROW_QUIET, '0},
        '{8'h04,          ROW_QUIET, '0},
        '{END_BYTE_RST,   ROW_ONE,   '{CMD_55, 8'h04, 8'h00, 1'b0, 1'b1}},
        '{START_BYTE_RST, ROW_QUIET, '0},
        '{CMD_60,         ROW_QUIET, '0},
        '{8'h05,          ROW_QUIET, '0},
        '{8'hA5,          ROW_QUIET, '0},
        '{END_BYTE_RST,   ROW_ONE,   '{CMD_60, 8'h05, 8'hA5, 1'b1, 1'b1}}
    };

    serial_frame_deframer #(
        .MAX_BODY(BODY_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_command      (o_command),
        .o_frame_length (o_frame_length),
        .o_payload_byte (o_payload_byte),
        .o_payload_valid(o_payload_valid),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic known_command(input t_byte c);
        case (c)
            CMD_20, CMD_25, CMD_26, CMD_27, CMD_55, CMD_60: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Advance the frame model by one byte; accepted frames land in frame_replay.
    function automatic void deframe_byte(input t_byte b);
        t_byte cmd;
        t_byte len;
        int    n;
        if (!fr_open) begin
            if (b == cfg_start) begin
                fr_open  = 1'b1;
                body_len = 0;
            end
            return;
        end
        if (b != cfg_end) begin
            if (body_len >= BODY_DEPTH) begin
                fr_open  = 1'b0;
                body_len = 0;
            end else begin
                body_buf[body_len] = b;
                body_len++;
            end
            return;
        end
        fr_open = 1'b0;
        if (body_len < 2)
            return;
        cmd = body_buf[0];
        len = body_buf[1];
        n   = body_len - 2;
        if (int'(len) != body_len + 2 || !known_command(cmd))
            return;
        if (n == 0)
            frame_replay.push_back('{cmd, len, 8'h00, 1'b0, 1'b1});
        for (int i = 0; i < n; i++)
            frame_replay.push_back('{cmd, len, body_buf[i + 2], 1'b1, 1'(i == n - 1)});
    endfunction

    function automatic t_byte pick_other(input t_byte avoid);
        t_byte r;
        do r = t_byte'($urandom_range(0, 255)); while (r == avoid);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Result checking, model update on accepted items and register writes.
    always @(posedge i_clk) begin : watch_ports
        t_frame_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got %0h %0h %0h %0b %0b",
                             $time, o_command, o_frame_length, o_payload_byte,
                             o_payload_valid, o_last);
                end else begin
                    want = due_results.pop_front();
                    check_field("command", want.command, o_command);
                    check_field("frame_length", want.frame_length, o_frame_length);
                    check_field("payload_byte", want.payload_byte, o_payload_byte);
                    check_field("payload_valid", 8'(want.payload_valid),
                                8'(o_payload_valid));
                    check_field("last", 8'(want.is_last), 8'(o_last));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_START_BYTE)
                    cfg_start = i_cfg_data;
                else if (i_cfg_index == CFG_END_BYTE)
                    cfg_end = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                frame_replay.delete();
                deframe_byte(i_rx_byte);
                case (row_chk)
                    ROW_ONE:   due_results.push_back(row_res);
                    ROW_QUIET: ;
                    default:   foreach (frame_replay[i]) due_results.push_back(frame_replay[i]);
                endcase
            end
        end
    end

    // Output backpressure: a random hold-off after each result, with calm stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if ($urandom_range(0, 15) == 0)
                    out_calm = ~out_calm;
                stall_left = out_calm ? 0 : $urandom_range(0, 5);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_item(input t_byte b, input t_row_check chk,
                             input t_frame_result res, input logic tally);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        row_chk    <= chk;
        row_res    <= res;
        do @(posedge i_clk); while (o_in_stall);
        if (tally)
            frame_items++;
    endtask

    task automatic send_frame(input t_frame_kind kind);
        int    n;
        t_byte cmd;
        t_byte len;
        case (kind)
            FR_NOISE: begin
                repeat ($urandom_range(1, 3))
                    send_item(pick_other(cfg_start), ROW_MODEL, '0, 1'b0);
            end
            FR_SHORT: begin
                send_item(cfg_start, ROW_MODEL, '0, 1'b1);
                if ($urandom_range(0, 1))
                    send_item(pick_other(cfg_end), ROW_MODEL, '0, 1'b1);
                send_item(cfg_end, ROW_MODEL, '0, 1'b1);
            end
            FR_OVERFLOW: begin
                send_item(cfg_start, ROW_MODEL, '0, 1'b1);
                repeat (BODY_DEPTH + 1)
                    send_item(pick_other(cfg_end), ROW_MODEL, '0, 1'b1);
            end
            default: begin
                if (kind == FR_MAX)
                    n = BODY_DEPTH - 2;
                else if ($urandom_range(0, 3) == 0)
                    n = $urandom_range(0, BODY_DEPTH - 2);
                else
                    n = $urandom_range(0, 4);
                cmd = good_cmds[$urandom_range(0, 5)];
                if (kind == FR_BADCMD)
                    do cmd = t_byte'($urandom_range(0, 255)); while (known_command(cmd));
                len = t_byte'(n + 4);
                if (kind == FR_BADLEN)
                    len = len ^ (t_byte'(1) << $urandom_range(0, 7));
                send_item(cfg_start, ROW_MODEL, '0, 1'b1);
                send_item(cmd, ROW_MODEL, '0, 1'b1);
                send_item(len, ROW_MODEL, '0, 1'b1);
                repeat (n) begin
                    // now and then a start byte inside the body
                    if ($urandom_range(0, 7) == 0 && cfg_start != cfg_end)
                        send_item(cfg_start, ROW_MODEL, '0, 1'b1);
                    else
                        send_item(pick_other(cfg_end), ROW_MODEL, '0, 1'b1);
                end
                send_item(cfg_end, ROW_MODEL, '0, 1'b1);
            end
        endcase
    endtask

    // Stop feeding, let every due result arrive, then give the block time to settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_byte idx, input t_byte val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge i_clk);
    endtask

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return FR_GOOD;
        if (r < 66) return FR_MAX;
        if (r < 74) return FR_BADLEN;
        if (r < 82) return FR_BADCMD;
        if (r < 88) return FR_SHORT;
        if (r < 94) return FR_OVERFLOW;
        return FR_NOISE;
    endfunction

    initial begin : stimulus
        int target;
        t_frame_kind kind;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].rx, dir_rows[i].chk, dir_rows[i].res, 1'b1);

        for (int pass = 0; pass < NUM_PASSES; pass++) begin
            if (pass > 0) begin
                drain();
                case (pass)
                    1: begin
                        write_reg(CFG_START_BYTE, 8'h00);
                        write_reg(CFG_END_BYTE, 8'hFF);
                    end
                    2: begin
                        // one byte value both opens and closes
                        write_reg(CFG_START_BYTE, 8'h7E);
                        write_reg(CFG_END_BYTE, 8'h7E);
                    end
                    3: begin
                        write_reg(CFG_START_BYTE, 8'hFF);
                        write_reg(CFG_END_BYTE, 8'h00);
                        write_reg(REG_UNMAPPED, 8'h5A);
                    end
                    default: begin
                        write_reg(CFG_START_BYTE, t_byte'($urandom_range(0, 255)));
                        write_reg(CFG_END_BYTE, t_byte'($urandom_range(8'h80, 8'hFF)));
                    end
                endcase
            end
            target = frame_items + ITEMS_PER_PASS;
            while (frame_items < target) begin
                // first frames walk through every kind once
                kind = (frame_no <= int'(FR_NOISE)) ? t_frame_kind'(frame_no) : pick_kind();
                send_frame(kind);
                frame_no++;
                if ($urandom_range(0, 5) == 0)
                    send_calm = ~send_calm;
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
        end
        drain();

        $display("fed %0d frame items in %0d frames, checked %0d results", frame_items,
                 frame_no, results_seen);
        $display("%0d register writes over %0d start/end settings, %0d mismatches",
                 reg_writes, NUM_PASSES, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
